[src/fmp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types and fixed field widths for the Fibonacci-mod-m block with the
// Pisano period search.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int INDEX_W   = 60;
    localparam int MODULUS_W = 11;
    localparam int RESIDUE_W = 10;
    localparam int PERIOD_W  = 13;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 24;
    localparam int DIV_CNT_W = $clog2(INDEX_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FIB,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic ready;
        logic tbl_we;
        logic tbl_zero;
        logic div_sel;
        logic out_load;
    } ctrl_t;

endpackage
`default_nettype wire

[src/fibonacci_mod_pisano_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fibonacci_mod_pisano_top
// Fibonacci residue F(n) mod m, found through the Pisano period: the residues
// are stored in a table until the pair 0,1 recurs or a search bound is hit,
// then n mod period is taken bit-serially and the table is read at that place.
// ----------------------------------------------------------------------------
// channel  dir  width  contents (lsb first)
// s_*      in   72     index[59:0], modulus[70:60], zero pad
// m_*      out  24     residue[9:0], period[22:10], zero pad
//
// the Fibonacci steps (as many as the Pisano period of m, at most
//   min(index + m, TABLE_DEPTH)) and the 60 remainder steps all go
//   through one compare-subtract unit
// modulus 0 or 1: the table is not used
// reset clears the sequencer and output valid; the table needs no clearing
// a result waits in the output register while m_tready is low, and the
// block accepts no request until it has been placed there
// ----------------------------------------------------------------------------
module fibonacci_mod_pisano_top #(
    parameter int MOD_LIMIT   = 1024,
    parameter int TABLE_DEPTH = 6144
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [fmp_pkg::S_DATA_W-1:0] s_tdata,   // index, modulus
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [fmp_pkg::M_DATA_W-1:0] m_tdata    // residue, period
);
    import fmp_pkg::*;

    localparam int RES_W  = $clog2(MOD_LIMIT);
    localparam int M_W    = $clog2(MOD_LIMIT + 1);
    localparam int PER_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CSU_W  = (RES_W + 1 > PER_W + 1) ? RES_W + 1 : PER_W + 1;
    localparam int SUM_W  = INDEX_W + 1;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [INDEX_W-1:0]   n_reg, n_next;
    logic [M_W-1:0]       m_reg, m_next;
    logic                 trivial_reg, trivial_next;
    logic [PER_W-1:0]     bound_reg, bound_next;
    logic [RES_W-1:0]     prev_reg, prev_next;
    logic [RES_W-1:0]     cur_reg, cur_next;
    logic [PER_W-1:0]     pos_reg, pos_next;
    logic [PER_W-1:0]     period_reg, period_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0]     rd_data_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [RES_W-1:0]     tbl [TABLE_DEPTH];
    logic [ADDR_W-1:0]    tbl_addr;
    logic [RES_W-1:0]     tbl_din;

    logic [INDEX_W-1:0]   in_index;
    logic [MODULUS_W-1:0] in_modulus;
    logic                 in_trivial;
    logic [M_W-1:0]       m_sat;
    logic [SUM_W-1:0]     bound_sum;

    logic [CSU_W-1:0]     csu_a, csu_b, csu_y;
    logic                 csu_ge;
    logic [RES_W-1:0]     nxt;
    logic                 at_bound, wrap, fib_done, div_done, load_ok;

    assign in_index   = s_tdata[INDEX_W-1:0];
    assign in_modulus = s_tdata[INDEX_W+MODULUS_W-1:INDEX_W];
    assign in_trivial = in_modulus <= MODULUS_W'(1);
    assign m_sat      = (32'(in_modulus) > MOD_LIMIT) ? M_W'(MOD_LIMIT) : M_W'(in_modulus);
    assign bound_sum  = SUM_W'(n_reg) + SUM_W'(m_reg);

    // shared compare-subtract: fibonacci add mod m, or one restoring remainder step
    always_comb
    begin
        if (ctrl.div_sel)
        begin
            csu_a = CSU_W'({rem_reg, n_reg[INDEX_W-1]});
            csu_b = CSU_W'(period_reg);
        end
        else
        begin
            csu_a = CSU_W'(prev_reg) + CSU_W'(cur_reg);
            csu_b = CSU_W'(m_reg);
        end
        csu_ge = csu_a >= csu_b;
        csu_y  = csu_ge ? csu_a - csu_b : csu_a;
    end

    assign nxt      = csu_y[RES_W-1:0];
    assign at_bound = pos_reg == bound_reg;
    assign wrap     = (cur_reg == '0) && (nxt == RES_W'(1));
    assign fib_done = at_bound || wrap;
    assign div_done = cnt_reg == DIV_CNT_W'(INDEX_W - 1);
    assign load_ok  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = in_trivial ? ST_LOAD : ST_SETUP;
            end
            ST_SETUP:
                state_next = ST_FIB;
            ST_FIB:
            begin
                if (fib_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
                ctrl.ready = 1'b1;
            ST_SETUP:
            begin
                ctrl.tbl_we   = 1'b1;
                ctrl.tbl_zero = 1'b1;
            end
            ST_FIB:
                ctrl.tbl_we = pos_reg < PER_W'(TABLE_DEPTH);
            ST_DIV:
                ctrl.div_sel = 1'b1;
            ST_READ:
                ctrl = '0;
            ST_LOAD:
                ctrl.out_load = load_ok;
            default:
                ctrl = '0;
        endcase
    end

    assign tbl_addr = ctrl.tbl_zero ? '0 : pos_reg[ADDR_W-1:0];
    assign tbl_din  = ctrl.tbl_zero ? '0 : cur_reg;

    always_comb
    begin
        n_next        = n_reg;
        m_next        = m_reg;
        trivial_next  = trivial_reg;
        bound_next    = bound_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        period_next   = period_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (ctrl.ready && s_tvalid)
        begin
            n_next       = in_index;
            m_next       = m_sat;
            trivial_next = in_trivial;
            period_next  = PER_W'(1);
        end

        if (ctrl.tbl_zero)
        begin
            bound_next = (bound_sum > SUM_W'(TABLE_DEPTH)) ? PER_W'(TABLE_DEPTH)
                                                          : bound_sum[PER_W-1:0];
            prev_next  = '0;
            cur_next   = RES_W'(1);
            pos_next   = PER_W'(1);
            rem_next   = '0;
            cnt_next   = '0;
        end

        if (state_reg == ST_FIB)
        begin
            if (at_bound)
                period_next = bound_reg;
            else if (wrap)
                period_next = pos_reg;
            else
            begin
                prev_next = cur_reg;
                cur_next  = nxt;
                pos_next  = pos_reg + PER_W'(1);
            end
        end

        // remainder of index by period, one index bit per cycle from the top
        if (ctrl.div_sel)
        begin
            rem_next = csu_y[PER_W-1:0];
            n_next   = {n_reg[INDEX_W-2:0], 1'b0};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end

        if (ctrl.out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'({PERIOD_W'(period_reg),
                                       trivial_reg ? RESIDUE_W'(0) : RESIDUE_W'(rd_data_reg)});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        m_reg       <= m_next;
        trivial_reg <= trivial_next;
        bound_reg   <= bound_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        pos_reg     <= pos_next;
        period_reg  <= period_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tbl_we)
            tbl[tbl_addr] <= tbl_din;
    end

    // remainder is below period, so it always lands inside the table
    always_ff @(posedge clk)
    begin
        rd_data_reg <= tbl[rem_reg[ADDR_W-1:0]];
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_pos_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIB) |-> (pos_reg <= bound_reg))
        else $error("sequence position passed the search bound");

    a_res_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIB) |-> (M_W'(prev_reg) < m_reg && M_W'(cur_reg) < m_reg))
        else $error("fibonacci residue not reduced below modulus");

    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_READ)
            |-> (period_reg != '0 && rem_reg < period_reg))
        else $error("remainder not below period");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && load_ok) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished request not presented");

endmodule
`default_nettype wire

[test/fibonacci_mod_pisano_top_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fibonacci_mod_pisano_top_tb
// Self-checking bench for the Fibonacci-mod-m block. Queries (index, modulus)
// are streamed in with random gaps, results are taken with random stalls, and
// each result is checked against a Pisano-period predictor kept in the bench.
// ----------------------------------------------------------------------------
module fibonacci_mod_pisano_top_tb;

    import fmp_pkg::*;

    localparam int MOD_LIMIT   = 1024;
    localparam int TABLE_DEPTH = 6144;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int RANDOM_QUERIES = 80;

    typedef struct {
        logic [INDEX_W-1:0]   index;
        logic [MODULUS_W-1:0] modulus;
    } fib_query_t;

    typedef struct {
        logic [RESIDUE_W-1:0] residue;
        logic [PERIOD_W-1:0]  period;
    } fib_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    fib_query_t  query_q[$];
    fib_result_t residue_due[$];
    logic [RESIDUE_W-1:0] residue_tab [TABLE_DEPTH];

    int unsigned queries_sent = 0;
    int unsigned results_seen = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned errors = 0;

    fibonacci_mod_pisano_top #(
        .MOD_LIMIT   (MOD_LIMIT),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // fills the residue table until 0,1 recurs or the search bound is hit
    function automatic fib_result_t pisano_fib(logic [INDEX_W-1:0] idx,
                                               logic [MODULUS_W-1:0] modv);
        longint unsigned n;
        longint unsigned m;
        longint unsigned bound;
        longint unsigned per;
        longint unsigned pos;
        int unsigned     prev;
        int unsigned     cur;
        int unsigned     nxt;
        fib_result_t     r;
        n = 64'(idx);
        m = 64'(modv);
        if (m <= 1)
        begin
            r.residue = '0;
            r.period  = PERIOD_W'(1);
            return r;
        end
        if (m > MOD_LIMIT)
            m = 64'(MOD_LIMIT);
        bound = n + m;
        if (bound > TABLE_DEPTH)
            bound = 64'(TABLE_DEPTH);
        residue_tab[0] = '0;
        residue_tab[1] = RESIDUE_W'(1);
        prev = 0;
        cur  = 1;
        per  = bound;
        for (pos = 2; pos <= bound; pos++)
        begin
            nxt = 32'((prev + cur) % m);
            if (pos < TABLE_DEPTH)
                residue_tab[TAB_AW'(pos)] = nxt[RESIDUE_W-1:0];
            if (cur == 0 && nxt == 1)
            begin
                per = pos - 1;
                break;
            end
            prev = cur;
            cur  = nxt;
        end
        r.residue = residue_tab[TAB_AW'(n % per)];
        r.period  = per[PERIOD_W-1:0];
        return r;
    endfunction

    // alternating stretches of 16 requests run with no idling at all
    function automatic int unsigned pick_gap(bit no_idle);
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic add_query(logic [INDEX_W-1:0] idx, logic [MODULUS_W-1:0] modv);
        fib_query_t q;
        q.index   = idx;
        q.modulus = modv;
        query_q.push_back(q);
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                residue_due.push_back(pisano_fib(s_tdata[INDEX_W-1:0],
                                                 s_tdata[INDEX_W +: MODULUS_W]));
                queries_sent <= queries_sent + 1;
            end
            if (s_tvalid && !s_tready)
                ;
            else if (tx_gap != 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (query_q.size() != 0)
            begin
                fib_query_t q;
                q = query_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_DATA_W - INDEX_W - MODULUS_W){1'b0}}, q.modulus, q.index};
                tx_gap   <= pick_gap(queries_sent[4]);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            int unsigned g;
            int unsigned bad;
            fib_result_t want;
            logic [RESIDUE_W-1:0] got_residue;
            logic [PERIOD_W-1:0]  got_period;
            bad = 0;
            got_residue = m_tdata[RESIDUE_W-1:0];
            got_period  = m_tdata[RESIDUE_W +: PERIOD_W];
            if (residue_due.size() == 0)
            begin
                $display("%0t: result with no request pending, residue %0d period %0d",
                         $time, got_residue, got_period);
                bad = bad + 1;
            end
            else
            begin
                want = residue_due.pop_front();
                if (got_residue !== want.residue)
                begin
                    $display("%0t: residue mismatch, expected %0d, got %0d",
                             $time, want.residue, got_residue);
                    bad = bad + 1;
                end
                if (got_period !== want.period)
                begin
                    $display("%0t: period mismatch, expected %0d, got %0d",
                             $time, want.period, got_period);
                    bad = bad + 1;
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            results_seen <= results_seen + 1;
            g = pick_gap(results_seen[4]);
            rx_stall <= g;
            m_tready <= (g == 0);
        end
        else if (rx_stall != 0)
        begin
            rx_stall <= rx_stall - 1;
            m_tready <= (rx_stall == 1);
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [INDEX_W-1:0]   idx;
        logic [MODULUS_W-1:0] modv;
        int unsigned sel;

        // modulus zero and one, saturation, bound reached before the period
        add_query('0, 0);
        add_query('1, 1);
        add_query(12345, 0);
        add_query(0, 2);
        add_query(1, 2);
        add_query('1, 2);
        add_query(0, 1024);
        add_query(1, 1024);
        add_query(1536, 1024);
        add_query('1, 1024);
        add_query('1, 2047);
        add_query({15{4'h5}}, 11'h555);
        add_query({15{4'hA}}, 11'h2AA);
        add_query(5, 1000);
        add_query(1499, 1000);
        add_query(2000, 1000);
        add_query('1, 10);
        add_query('1, 250);
        add_query(3, 3);
        add_query(60, 10);
        add_query(1, 1);

        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                modv = MODULUS_W'($urandom_range(2, 64));
            else if (sel < 9)
                modv = MODULUS_W'($urandom_range(0, 2047));
            else
                modv = ($urandom_range(0, 1) == 0) ? MODULUS_W'($urandom_range(0, 1))
                                                   : MODULUS_W'($urandom_range(1024, 2047));
            if ($urandom_range(0, 4) < 2)
                idx = INDEX_W'($urandom_range(0, 100));
            else
                idx = INDEX_W'({$urandom, $urandom});
            add_query(idx, modv);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (query_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (residue_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0 && residue_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

[fibonacci_mod_pisano_top.f]
src/fmp_pkg.sv
src/fibonacci_mod_pisano_top.sv
test/fibonacci_mod_pisano_top_tb.sv
